>>> src/ggc_pkg.sv
// Shared types and constants for the greedy graph colouring unit.
// Used by every module of the block; depends on nothing.
package ggc_pkg;

   // Fixed field widths of the request and response items
   localparam int VTX_W   = 6;
   localparam int COLOR_W = 6;
   localparam int COUNT_W = 7;
   localparam int REQ_DATA_W = 72;   // vertex + neighbour row, padded to bytes
   localparam int RSP_DATA_W = 24;   // vertex, colour, colours used, padded

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

   // Request kinds carried on tuser
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_COLOR = 1'b1;

   // Sequencer states
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ROW   = 6'b000010,
      ST_WALK  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_DONE  = 6'b100000
   } ggc_state_type;

   // Access to the colour store
   typedef struct packed {
      logic               we;
      logic               set_valid;
      logic [VTX_W-1:0]   waddr;
      logic [COLOR_W-1:0] wcolor;
      logic               re;
      logic [VTX_W-1:0]   raddr;
   } ggc_color_req_type;

   typedef struct packed {
      logic               valid;
      logic [COLOR_W-1:0] color;
   } ggc_color_rsp_type;

   // One finished colouring result
   typedef struct packed {
      logic [COUNT_W-1:0] colors_used;
      logic [COLOR_W-1:0] assigned_color;
      logic [VTX_W-1:0]   vertex_done;
   } ggc_result_type;

endpackage

>>> src/ggc_adj_mem.sv
// Adjacency row memory: one row of neighbour bits per vertex.
// One write port, one registered read port; no reset on contents.
module ggc_adj_mem
   import ggc_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic                            clock,
   input  logic                            we,
   input  logic [$clog2(MAX_VERTICES)-1:0] waddr,
   input  logic [MAX_VERTICES-1:0]         wdata,
   input  logic                            re,
   input  logic [$clog2(MAX_VERTICES)-1:0] raddr,
   output logic [MAX_VERTICES-1:0]         rdata
);

   logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] rdata_ff;

   // Write a row on load
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/ggc_color_store.sv
// Colour store: a colour value per vertex in memory plus a valid bit per
// vertex in flip-flops that reset clears. Uses ggc_pkg.
module ggc_color_store
   import ggc_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  ggc_color_req_type req,
   output ggc_color_rsp_type rsp
);

   localparam int IDX_W = $clog2(MAX_VERTICES);

   logic [COLOR_W-1:0]      mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] valid_ff;
   logic [COLOR_W-1:0]      rd_color_ff;
   logic                    rd_valid_ff;

   // Valid bits: cleared at reset, set on colouring, cleared on load
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.we) begin
         valid_ff[req.waddr[IDX_W-1:0]] <= req.set_valid;
      end
   end

   // Colour values
   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr[IDX_W-1:0]] <= req.wcolor;
      end
   end

   // Registered read of colour and valid bit together
   always_ff @(posedge clock) begin
      if (req.re) begin
         rd_color_ff <= mem[req.raddr[IDX_W-1:0]];
         rd_valid_ff <= valid_ff[req.raddr[IDX_W-1:0]];
      end
   end

   assign rsp.valid = rd_valid_ff;
   assign rsp.color = rd_color_ff;

endmodule

>>> src/ggc_ctrl.sv
// Sequencer and datapath: walks a vertex's neighbours one per cycle,
// marks blocked colours, then scans for the first free colour.
// Uses ggc_pkg; drives ggc_adj_mem and ggc_color_store.
module ggc_ctrl
   import ggc_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // request side
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [VTX_W-1:0]                  req_vertex,
   // vertex count in effect, already clamped
   input  logic [$clog2(MAX_VERTICES+1)-1:0] n_eff,
   // adjacency memory
   output logic                              adj_we,
   output logic [$clog2(MAX_VERTICES)-1:0]   adj_waddr,
   output logic                              adj_re,
   output logic [$clog2(MAX_VERTICES)-1:0]   adj_raddr,
   input  logic [MAX_VERTICES-1:0]           adj_rdata,
   // colour store
   output ggc_color_req_type                 col_req,
   input  ggc_color_rsp_type                 col_rsp,
   // result
   input  logic                              slot_free,
   output logic                              res_push,
   output ggc_result_type                    res
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES+1);

   ggc_state_type           state_ff, state_in;
   logic [VTX_W-1:0]        v_ff, v_in;
   logic [IDX_W-1:0]        j_ff, j_in;
   logic [IDX_W-1:0]        pj_ff, pj_in;
   logic                    pend_ff, pend_in;
   logic [IDX_W-1:0]        c_ff, c_in;
   logic [MAX_VERTICES-1:0] row_ff, row_in;
   logic [MAX_VERTICES-1:0] blocked_ff, blocked_in;
   logic [CNT_W-1:0]        highest_ff, highest_in;

   logic             accept;
   logic             color_ok;
   logic             load_ok;
   logic [CNT_W-1:0] n_m1;
   logic [CNT_W-1:0] cand;
   logic             last_j;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign n_m1      = n_eff - CNT_W'(1);
   assign color_ok  = (COUNT_W'(req_vertex) < COUNT_W'(n_eff));
   assign load_ok   = (COUNT_W'(req_vertex) < COUNT_W'(MAX_VERTICES));
   assign last_j    = (CNT_W'(j_ff) == n_m1);
   assign cand      = CNT_W'(c_ff) + CNT_W'(1);

   // Memory addresses
   assign adj_waddr = req_vertex[IDX_W-1:0];
   assign adj_raddr = req_vertex[IDX_W-1:0];
   assign adj_we    = accept && (req_cmd == CMD_LOAD) && load_ok;
   assign adj_re    = accept && (req_cmd == CMD_COLOR) && color_ok;

   // Next-state and datapath
   always_comb begin
      state_in   = state_ff;
      v_in       = v_ff;
      j_in       = j_ff;
      pj_in      = pj_ff;
      pend_in    = 1'b0;
      c_in       = c_ff;
      row_in     = row_ff;
      blocked_in = blocked_ff;
      highest_in = highest_ff;
      res_push   = 1'b0;
      col_req    = '0;

      // Fold in the neighbour colour read in the previous cycle
      if (pend_ff && row_ff[pj_ff] && col_rsp.valid &&
          (COUNT_W'(col_rsp.color) < COUNT_W'(n_eff))) begin
         blocked_in[col_rsp.color[IDX_W-1:0]] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            blocked_in = '0;
            if (accept) begin
               if (req_cmd == CMD_LOAD) begin
                  // drop the old colour of a reloaded vertex
                  if (load_ok) begin
                     col_req.we        = 1'b1;
                     col_req.set_valid = 1'b0;
                     col_req.waddr     = req_vertex;
                  end
               end else if (color_ok) begin
                  v_in     = req_vertex;
                  state_in = ST_ROW;
               end
            end
         end
         ST_ROW: begin
            // mask neighbours beyond the count and the self loop
            for (int i = 0; i < MAX_VERTICES; i++) begin
               row_in[i] = adj_rdata[i] && (CNT_W'(i) < n_eff) &&
                           (IDX_W'(i) != v_ff[IDX_W-1:0]);
            end
            j_in     = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            col_req.re    = 1'b1;
            col_req.raddr = VTX_W'(j_ff);
            pend_in       = 1'b1;
            pj_in         = j_ff;
            if (last_j) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            c_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if ((CNT_W'(c_ff) < n_m1) && blocked_ff[c_ff]) begin
               c_in = c_ff + IDX_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               col_req.we        = 1'b1;
               col_req.set_valid = 1'b1;
               col_req.waddr     = v_ff;
               col_req.wcolor    = COLOR_W'(c_ff);
               if (cand > highest_ff) begin
                  highest_in = cand;
               end
               res_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result as shown at the push
   always_comb begin
      res.vertex_done    = v_ff;
      res.assigned_color = COLOR_W'(c_ff);
      res.colors_used    = (cand > highest_ff) ? COUNT_W'(cand) : COUNT_W'(highest_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pend_ff    <= 1'b0;
         highest_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         highest_ff <= highest_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      v_ff       <= v_in;
      j_ff       <= j_in;
      pj_ff      <= pj_in;
      c_ff       <= c_in;
      row_ff     <= row_in;
      blocked_ff <= blocked_in;
   end

endmodule

>>> src/greedy_graph_coloring_unit.sv
// Greedy first-fit graph colouring unit, top level.
// Load item: ready again the next cycle. Colour item: row read, neighbour walk
// through the colour store read port, free-colour scan, write-back.
// One item at a time; a finished result waits in the output register.
// Synchronous reset: all vertices uncoloured, colours used 0, vertex_count 64.
module greedy_graph_coloring_unit
   import ggc_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // request: tdata = vertex[5:0], neighbor_bits[69:6]; tuser = command
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   // response: tdata = vertex_done[5:0], assigned_color[11:6], colors_used[18:12]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // vertex_count register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COUNT_W-1:0]    csr_wdata
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES+1);

   logic [COUNT_W-1:0]      vcount_ff;
   logic [CNT_W-1:0]        n_eff;
   logic                    out_valid_ff;
   ggc_result_type          out_ff;
   logic                    slot_free;
   logic                    res_push;
   ggc_result_type          res;
   logic                    adj_we, adj_re;
   logic [IDX_W-1:0]        adj_waddr, adj_raddr;
   logic [MAX_VERTICES-1:0] adj_rdata;
   ggc_color_req_type       col_req;
   ggc_color_rsp_type       col_rsp;

   // Vertex count register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VERTEX_COUNT_RESET;
      end else if (csr_valid) begin
         vcount_ff <= csr_wdata;
      end
   end

   // Clamp the count to 1..MAX_VERTICES
   always_comb begin
      if (vcount_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (vcount_ff > COUNT_W'(MAX_VERTICES)) begin
         n_eff = CNT_W'(MAX_VERTICES);
      end else begin
         n_eff = CNT_W'(vcount_ff);
      end
   end

   ggc_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tuser),
      .req_vertex (req_tdata[VTX_W-1:0]),
      .n_eff      (n_eff),
      .adj_we     (adj_we),
      .adj_waddr  (adj_waddr),
      .adj_re     (adj_re),
      .adj_raddr  (adj_raddr),
      .adj_rdata  (adj_rdata),
      .col_req    (col_req),
      .col_rsp    (col_rsp),
      .slot_free  (slot_free),
      .res_push   (res_push),
      .res        (res)
   );

   ggc_adj_mem #(.MAX_VERTICES(MAX_VERTICES)) u_adj (
      .clock (clock),
      .we    (adj_we),
      .waddr (adj_waddr),
      .wdata (req_tdata[VTX_W +: MAX_VERTICES]),
      .re    (adj_re),
      .raddr (adj_raddr),
      .rdata (adj_rdata)
   );

   ggc_color_store #(.MAX_VERTICES(MAX_VERTICES)) u_col (
      .clock (clock),
      .reset (reset),
      .req   (col_req),
      .rsp   (col_rsp)
   );

   // Output register: hold a result until its transfer
   assign slot_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_push) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(ggc_result_type)){1'b0}}, out_ff};

endmodule

>>> src/ggc_checker.sv
// Port-level checks for the greedy graph colouring unit, bound to the top level.
// Uses ggc_pkg for field widths.
module ggc_checker
   import ggc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // The assigned colour is always below the count of colours in use
   a_color_below_used: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[11:6]} < rsp_tdata[18:12]))
      else $error("assigned colour not below colours used");

   // A result always reports at least one colour in use
   a_used_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[18:12] != 7'd0)
      else $error("colours used is zero in a result");

   // A load transfer leaves the unit ready for the next request
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_LOAD) |=> req_tready)
      else $error("not ready after a load");

   // No response straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind greedy_graph_coloring_unit ggc_checker u_ggc_checker (.*);

>>> verif/testbench.sv
// Self-checking testbench for the greedy first-fit graph colouring unit.
// Drives load and colour transfers, predicts every colouring result locally
// and checks each response; depends only on ggc_pkg and the top level.
module testbench;
   import ggc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_VERTICES   = 64;
   localparam int SETTLE_CYCLES  = 2 * NUM_VERTICES + 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 400;
   localparam int CLIQUE_PHASE   = 6;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // vertex[5:0], neighbor_bits[69:6]
   logic                  req_tuser = CMD_LOAD;   // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // vertex_done, assigned_color, colors_used
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_W-1:0]    csr_wdata = '0;

   // Local copy of the colouring state
   logic [63:0]        adj_store [NUM_VERTICES];
   logic [COLOR_W-1:0] color_store [NUM_VERTICES];
   logic [63:0]        colored_mask;
   logic [63:0]        row_written;
   logic [COUNT_W-1:0] colors_in_use;
   logic [COUNT_W-1:0] count_setting;
   ggc_result_type     expected_colorings [$];

   int error_count = 0;
   int sent_count = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   bit hold_pending = 1'b0;

   greedy_graph_coloring_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Vertex count in effect, clamped to 1..NUM_VERTICES
   function automatic int active_vertices();
      if (count_setting == 0) return 1;
      if (int'(count_setting) > NUM_VERTICES) return NUM_VERTICES;
      return int'(count_setting);
   endfunction

   // Update the local state for one accepted transfer; queue any colouring
   task automatic predict_transfer(input logic cmd, input logic [5:0] vtx,
                                   input logic [63:0] bits);
      int n;
      int j;
      int c;
      logic [63:0] row;
      logic [63:0] blocked;
      ggc_result_type res;
      n = active_vertices();
      if (cmd == CMD_LOAD) begin
         adj_store[vtx] = bits;
         colored_mask[vtx] = 1'b0;
         color_store[vtx] = '0;
         row_written[vtx] = 1'b1;
         return;
      end
      if (int'(vtx) >= n) return;
      row = adj_store[vtx] & ((n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1));
      row[vtx] = 1'b0;
      blocked = '0;
      // A neighbour colour at or above the count blocks nothing
      for (j = 0; j < n; j++) begin
         if (row[j] && colored_mask[j] && int'(color_store[j]) < n)
            blocked[color_store[j]] = 1'b1;
      end
      c = 0;
      while (c < n - 1 && blocked[c]) c++;
      colored_mask[vtx] = 1'b1;
      color_store[vtx] = COLOR_W'(c);
      if (c + 1 > int'(colors_in_use)) colors_in_use = COUNT_W'(c + 1);
      res.vertex_done = vtx;
      res.assigned_color = COLOR_W'(c);
      res.colors_used = colors_in_use;
      expected_colorings.push_back(res);
   endtask

   // Offer one item, wait for its transfer, then maybe open a gap
   task automatic send_item(input logic cmd, input logic [5:0] vtx,
                            input logic [63:0] bits);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, bits, vtx};
      req_tuser <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_transfer(cmd, vtx, bits);
      sent_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         burst_left = $urandom_range(0, 40);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the input until every colouring has returned and the block settled
   task automatic wait_all_colored();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_colorings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [COUNT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      count_setting = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] random_row(input int density);
      logic [63:0] r1;
      logic [63:0] r2;
      r1 = {$urandom, $urandom};
      r2 = {$urandom, $urandom};
      case (density)
         0: return r1 & r2;
         1: return r1;
         2: return r1 | r2;
         default: return {64{1'b1}};
      endcase
   endfunction

   // Loaded vertex below the count in effect, or -1 if there is none
   function automatic int pick_loaded_below(input int n);
      int cand [$];
      int v;
      for (v = 0; v < n; v++) if (row_written[v]) cand.push_back(v);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
   endfunction

   task automatic test_single_vertex_extremes();
      send_item(CMD_LOAD, 6'd0, {64{1'b1}});
      send_item(CMD_COLOR, 6'd0, '0);
      send_item(CMD_LOAD, 6'd63, {64{1'b1}});
      send_item(CMD_COLOR, 6'd63, {64{1'b1}});
      // recolour: its own old colour does not count
      send_item(CMD_COLOR, 6'd63, '0);
      // self loop only
      send_item(CMD_LOAD, 6'd5, 64'd1 << 5);
      send_item(CMD_COLOR, 6'd5, '0);
      send_item(CMD_LOAD, 6'd1, '0);
      send_item(CMD_COLOR, 6'd1, '0);
      // reload clears the colour of vertex 0
      send_item(CMD_LOAD, 6'd0, {64{1'b1}});
      send_item(CMD_COLOR, 6'd63, '0);
   endtask

   task automatic test_count_clamping();
      wait_all_colored();
      write_vertex_count(7'd0);
      send_item(CMD_COLOR, 6'd0, '0);
      // vertex above the count: dropped without a result
      send_item(CMD_COLOR, 6'd1, '0);
      wait_all_colored();
      write_vertex_count(7'd127);
      send_item(CMD_COLOR, 6'd63, '0);
      wait_all_colored();
      write_vertex_count(7'd100);
      send_item(CMD_COLOR, 6'd1, '0);
   endtask

   task automatic test_stale_neighbour_color();
      wait_all_colored();
      write_vertex_count(7'd16);
      send_item(CMD_LOAD, 6'd1, {64{1'b1}});
      send_item(CMD_LOAD, 6'd2, 64'h1E);
      send_item(CMD_LOAD, 6'd3, 64'h1E);
      send_item(CMD_LOAD, 6'd4, 64'h1E);
      send_item(CMD_COLOR, 6'd2, '0);
      send_item(CMD_COLOR, 6'd3, '0);
      send_item(CMD_COLOR, 6'd4, '0);
      send_item(CMD_COLOR, 6'd1, '0);
      // vertex 1 now holds a colour at or above the reduced count
      wait_all_colored();
      write_vertex_count(7'd3);
      send_item(CMD_LOAD, 6'd0, 64'h2);
      send_item(CMD_COLOR, 6'd0, '0);
      send_item(CMD_COLOR, 6'd2, '0);
   endtask

   // Receiver holds off while the sender keeps offering colour items
   task automatic test_output_holdoff();
      int v;
      wait_all_colored();
      write_vertex_count(7'd8);
      for (v = 0; v < 8; v++) send_item(CMD_LOAD, 6'(v), random_row(2));
      burst_left = 100;
      hold_pending = 1'b1;
      for (v = 0; v < 8; v++) send_item(CMD_COLOR, 6'(v), random_row(1));
   endtask

   task automatic test_random_graphs();
      int target;
      int phase;
      int n;
      int density;
      int v;
      int k;
      int tmp;
      int pick;
      logic [COUNT_W-1:0] value;
      int order [$];
      target = sent_count + RANDOM_ITEMS;
      phase = 0;
      while (sent_count < target) begin
         wait_all_colored();
         if (phase == CLIQUE_PHASE) begin
            value = 7'd64;
         end else begin
            case ($urandom_range(0, 9))
               0: value = COUNT_W'($urandom_range(65, 127));
               1: value = 7'd0;
               2: value = 7'd1;
               3: value = COUNT_W'($urandom_range(13, 40));
               default: value = COUNT_W'($urandom_range(2, 12));
            endcase
         end
         write_vertex_count(value);
         n = active_vertices();
         density = (phase == CLIQUE_PHASE) ? 3 : $urandom_range(0, 3);
         // Load every vertex in use, then colour them in shuffled order
         order.delete();
         for (v = 0; v < n; v++) begin
            send_item(CMD_LOAD, 6'(v), random_row(density));
            order.push_back(v);
         end
         for (k = n - 1; k > 0; k--) begin
            pick = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[pick];
            order[pick] = tmp;
         end
         foreach (order[k]) send_item(CMD_COLOR, 6'(order[k]), random_row(1));
         // Mix in noise: dropped colours, stray loads, recolours
         repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(0, 3))
               0: begin
                  if (n < NUM_VERTICES)
                     send_item(CMD_COLOR, 6'($urandom_range(n, 63)), random_row(1));
                  else
                     send_item(CMD_COLOR, 6'($urandom_range(0, 63)), random_row(1));
               end
               1: begin
                  v = $urandom_range(0, 63);
                  send_item(CMD_LOAD, 6'(v), random_row($urandom_range(0, 3)));
                  if (v < n) send_item(CMD_COLOR, 6'(v), random_row(1));
               end
               2: begin
                  v = pick_loaded_below(n);
                  if (v >= 0) send_item(CMD_COLOR, 6'(v), random_row(1));
               end
               default: send_item(CMD_LOAD, 6'($urandom_range(0, 63)), random_row(1));
            endcase
         end
         phase++;
      end
   endtask

   task automatic compare_field(input string field, input int expected_value,
                                input int actual_value);
      if (expected_value != actual_value) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field,
                  expected_value, actual_value);
         error_count++;
      end
   endtask

   // Check every response transfer against the oldest expectation
   always @(posedge clock) begin
      ggc_result_type got;
      ggc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[COUNT_W+COLOR_W+VTX_W-1:0];
         if (expected_colorings.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual vertex %0d colour %0d used %0d",
                     $time, got.vertex_done, got.assigned_color, got.colors_used);
            error_count++;
         end else begin
            want = expected_colorings.pop_front();
            compare_field("vertex_done", want.vertex_done, got.vertex_done);
            compare_field("assigned_color", want.assigned_color, got.assigned_color);
            compare_field("colors_used", want.colors_used, got.colors_used);
         end
      end
   end

   // Receiver stall pattern, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_pending) begin
         hold_left = HOLD_CYCLES;
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 160);
         end
         stall_left--;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            default: rsp_tready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   // Drop the run when nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < NUM_VERTICES; i++) begin
         adj_store[i] = '0;
         color_store[i] = '0;
      end
      colored_mask = '0;
      row_written = '0;
      colors_in_use = '0;
      count_setting = VERTEX_COUNT_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_vertex_extremes();
      test_count_clamping();
      test_stale_neighbour_color();
      test_output_holdoff();
      test_random_graphs();

      wait_all_colored();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
